// ----- sv/diagonal_state_space_scan_defines.svh -----
// Assertion macros shared by the diagonal state-space scan RTL.
`ifndef DIAGONAL_STATE_SPACE_SCAN_DEFINES_SVH
`define DIAGONAL_STATE_SPACE_SCAN_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define DSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("diagonal_state_space_scan: check failed");
// Next-cycle implication, checked out of reset.
`define DSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("diagonal_state_space_scan: check failed");
`else
`define DSS_ASSERT_IMP(lbl, ante, cons)
`define DSS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/dss_pkg.sv -----
// Types, constants and rounding helper for the diagonal state-space scan.
`timescale 1ns / 1ps
package dss_pkg;

  localparam int NUM_MODES = 32;
  localparam int MODE_W    = $clog2(NUM_MODES);
  localparam int CNT_W     = $clog2(NUM_MODES + 1);
  localparam int IDX_W     = 5;

  // State accumulator covers decay*x twice plus the scaled gain term.
  localparam int ACC_S_W = 50;
  // Output accumulator adds two doubled readout terms per mode.
  localparam int ACC_Y_W = ACC_S_W + MODE_W;

  localparam int FRAC_DROP = 13;
  localparam int U_SHIFT   = 12;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic CFG_FEEDTHROUGH = 1'b0;
  localparam logic CFG_MODES       = 1'b1;

  typedef logic [2:0] mac_op_t;
  localparam mac_op_t OP_NONE    = 3'd0;
  localparam mac_op_t OP_S_LOAD  = 3'd1;
  localparam mac_op_t OP_S_ADD   = 3'd2;
  localparam mac_op_t OP_S_SUB   = 3'd3;
  localparam mac_op_t OP_S_ADDSH = 3'd4;
  localparam mac_op_t OP_Y_LDSH  = 3'd5;
  localparam mac_op_t OP_Y_ADD2  = 3'd6;
  localparam mac_op_t OP_Y_SUB2  = 3'd7;

  typedef struct packed {
    mac_op_t            op;
    logic signed [15:0] a;
    logic signed [31:0] b;
  } mac_req_t;

  typedef struct packed {
    logic signed [15:0] decay_re;
    logic signed [15:0] decay_im;
    logic signed [15:0] gain_re;
    logic signed [15:0] gain_im;
    logic signed [15:0] readout_re;
    logic signed [15:0] readout_im;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cstate_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } rsat_t;

  localparam logic signed [ACC_Y_W-1:0] RND_BIAS = ACC_Y_W'(4096);
  localparam logic signed [ACC_Y_W-1:0] SAT_MAX  = ACC_Y_W'(32'h7FFF_FFFF);
  localparam logic signed [ACC_Y_W-1:0] SAT_MIN  = ~SAT_MAX;

  // Drop 13 fraction bits, round to nearest with ties up, saturate to 32 bits.
  function automatic rsat_t round_sat(input logic signed [ACC_Y_W-1:0] v);
    logic signed [ACC_Y_W-1:0] t;
    logic signed [ACC_Y_W-1:0] q;
    rsat_t r;
    t = v + RND_BIAS;
    q = t >>> FRAC_DROP;
    if (q > SAT_MAX) begin
      r.sat = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (q < SAT_MIN) begin
      r.sat = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = q[31:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/diagonal_state_space_scan.sv -----
// Top level of the diagonal state-space scan: one channel of x = a*x + b*u, y = D*u + 2*Re(c*x).
//
// Input channel (in_valid / in_stall): a load item (action 0) writes the decay, gain
// and readout coefficients of one mode and clears that mode's state; it gives no
// result. A sample item (action 1) runs the recurrence over
// the active modes and gives one result transfer on the out_ channel.
// One shared 16x32 multiplier and its accumulators do all the arithmetic. Each mode
// steps through a memory read, eight multiplies and a state write-back. A sample
// runs over min(modes_in_use, 32) modes, and in_stall stays high while it is busy.
// The result sits in an output register; a new item is taken while it waits, and a
// sample finishing behind a stalled result holds in its last step until the
// register frees up. out_saturated flags any state part or the output clipping.
// Reset (rst_n low, synchronous) clears all mode states to zero through per-mode
// valid bits and sets feedthrough to 0 and modes_in_use to 32; coefficient memory
// is undefined until loaded. Write cfg_ registers only while the block is idle.
`timescale 1ns / 1ps
`include "diagonal_state_space_scan_defines.svh"
module diagonal_state_space_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_wdata,
  // Input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [dss_pkg::IDX_W-1:0] in_mode_index,
  input  logic signed [15:0]        in_decay_re,
  input  logic signed [15:0]        in_decay_im,
  input  logic signed [15:0]        in_gain_re,
  input  logic signed [15:0]        in_gain_im,
  input  logic signed [15:0]        in_readout_re,
  input  logic signed [15:0]        in_readout_im,
  input  logic signed [15:0]        in_sample,
  // Result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        out_y_out,
  output logic                      out_saturated
);
  import dss_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FEED  = 3'd1;
  localparam logic [2:0] ST_MODE  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [3:0] PH_READ = 4'd0;
  localparam logic [3:0] PH_M1   = 4'd1;
  localparam logic [3:0] PH_M2   = 4'd2;
  localparam logic [3:0] PH_M3   = 4'd3;
  localparam logic [3:0] PH_M4   = 4'd4;
  localparam logic [3:0] PH_M5   = 4'd5;
  localparam logic [3:0] PH_M6   = 4'd6;
  localparam logic [3:0] PH_M7   = 4'd7;
  localparam logic [3:0] PH_IMAG = 4'd8;
  localparam logic [3:0] PH_LAST = 4'd9;

  // Configuration registers
  logic signed [15:0] feedthrough_r;
  logic [5:0]         modes_r;

  // Sequencer
  logic [2:0]       st_r, st_nxt;
  logic [3:0]       ph_r, ph_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             last_mode;

  // Sample and per-mode intermediates
  logic signed [15:0] u_r;
  logic signed [31:0] sr_r;
  logic signed [31:0] si_r;
  logic               flag_r;

  // Memories and per-mode valid bits
  coef_t          coef_mem [NUM_MODES];
  cstate_t        state_mem [NUM_MODES];
  logic [NUM_MODES-1:0] st_vld_r;
  coef_t          coef_q_r;
  cstate_t        st_q_r;
  logic           vld_q_r;
  logic signed [31:0] xr;
  logic signed [31:0] xi;

  // Output register
  logic               out_valid_r;
  logic signed [31:0] out_y_r;
  logic               out_sat_r;

  // Datapath
  mac_req_t                  mreq;
  logic signed [ACC_S_W-1:0] acc_s;
  logic signed [ACC_Y_W-1:0] acc_y;
  rsat_t                     rs_s;
  rsat_t                     rs_y;

  logic in_xfer, ld_xfer, smp_xfer, ld_ok, out_free, wb_en;
  logic [MODE_W-1:0] mode_addr;

  assign in_stall  = (st_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign ld_xfer   = in_xfer && (in_action == ACT_LOAD);
  assign smp_xfer  = in_xfer && (in_action == ACT_SAMPLE);
  // Drop loads aimed past the last mode.
  assign ld_ok     = ld_xfer && ({27'd0, in_mode_index} < 32'(NUM_MODES));
  assign out_free  = !out_valid_r || !out_stall;
  assign mode_addr = n_r[MODE_W-1:0];
  assign last_mode = (CNT_W'(n_r + 1'b1) == cnt_r);
  assign wb_en     = (st_r == ST_MODE) && (ph_r == PH_LAST);

  // Clamp the active mode count to the memory depth.
  assign cnt_nxt = ({26'd0, modes_r} > 32'(NUM_MODES)) ? CNT_W'(NUM_MODES) : CNT_W'(modes_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feedthrough_r <= '0;
      modes_r       <= 6'd32;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FEEDTHROUGH) begin
        feedthrough_r <= cfg_wdata;
      end else begin
        modes_r <= cfg_wdata[5:0];
      end
    end
  end

  // Coefficient and state memories: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ld_ok) begin
      coef_mem[MODE_W'(in_mode_index)] <= '{in_decay_re, in_decay_im, in_gain_re,
                                            in_gain_im, in_readout_re, in_readout_im};
    end
    if (wb_en) begin
      state_mem[mode_addr] <= '{sr_r, si_r};
    end
    if ((st_r == ST_MODE) && (ph_r == PH_READ)) begin
      coef_q_r <= coef_mem[mode_addr];
      st_q_r   <= state_mem[mode_addr];
      vld_q_r  <= st_vld_r[mode_addr];
    end
  end

  // A mode whose valid bit is low reads as a zero state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
    end else if (ld_ok) begin
      st_vld_r[MODE_W'(in_mode_index)] <= 1'b0;
    end else if (wb_en) begin
      st_vld_r[mode_addr] <= 1'b1;
    end
  end

  assign xr = vld_q_r ? st_q_r.re : 32'sd0;
  assign xi = vld_q_r ? st_q_r.im : 32'sd0;

  // Operand selection for the shared multiplier, at most one product per phase.
  always_comb begin
    mreq = '{OP_NONE, 16'sd0, 32'sd0};
    if (st_r == ST_FEED) begin
      mreq = '{OP_Y_LDSH, feedthrough_r, 32'(u_r)};
    end else if (st_r == ST_MODE) begin
      unique case (ph_r)
        PH_M1:   mreq = '{OP_S_LOAD,  coef_q_r.decay_re,   xr};
        PH_M2:   mreq = '{OP_S_SUB,   coef_q_r.decay_im,   xi};
        PH_M3:   mreq = '{OP_S_ADDSH, coef_q_r.gain_re,    32'(u_r)};
        PH_M4:   mreq = '{OP_S_LOAD,  coef_q_r.decay_re,   xi};
        PH_M5:   mreq = '{OP_S_ADD,   coef_q_r.decay_im,   xr};
        PH_M6:   mreq = '{OP_S_ADDSH, coef_q_r.gain_im,    32'(u_r)};
        PH_M7:   mreq = '{OP_Y_ADD2,  coef_q_r.readout_re, sr_r};
        PH_LAST: mreq = '{OP_Y_SUB2,  coef_q_r.readout_im, si_r};
        default: mreq = '{OP_NONE, 16'sd0, 32'sd0};
      endcase
    end
  end

  dss_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .acc_s (acc_s),
    .acc_y (acc_y)
  );

  assign rs_s = round_sat(ACC_Y_W'(acc_s));
  assign rs_y = round_sat(acc_y);

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    ph_nxt = ph_r;
    n_nxt  = n_r;
    unique case (st_r)
      ST_IDLE: begin
        if (smp_xfer) begin
          st_nxt = ST_FEED;
        end
      end
      ST_FEED: begin
        ph_nxt = PH_READ;
        n_nxt  = '0;
        st_nxt = (cnt_r == '0) ? ST_DRAIN : ST_MODE;
      end
      ST_MODE: begin
        if (ph_r == PH_LAST) begin
          ph_nxt = PH_READ;
          if (last_mode) begin
            st_nxt = ST_DRAIN;
          end else begin
            n_nxt = CNT_W'(n_r + 1'b1);
          end
        end else begin
          ph_nxt = ph_r + 4'd1;
        end
      end
      ST_DRAIN: st_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ph_r <= PH_READ;
      n_r  <= '0;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      n_r  <= n_nxt;
    end
  end

  // Capture the sample, then the rounded state parts as they settle.
  always_ff @(posedge clk) begin
    if (smp_xfer) begin
      u_r   <= in_sample;
      cnt_r <= cnt_nxt;
    end
    if ((st_r == ST_MODE) && (ph_r == PH_M5)) begin
      sr_r <= rs_s.val;
    end
    if ((st_r == ST_MODE) && (ph_r == PH_IMAG)) begin
      si_r <= rs_s.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (smp_xfer) begin
      flag_r <= 1'b0;
    end else if ((st_r == ST_MODE) && ((ph_r == PH_M5) || (ph_r == PH_IMAG))) begin
      flag_r <= flag_r | rs_s.sat;
    end
  end

  // Output register: load when free, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((st_r == ST_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == ST_FIN) && out_free) begin
      out_y_r   <= rs_y.val;
      out_sat_r <= flag_r | rs_y.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_y_out     = out_y_r;
  assign out_saturated = out_sat_r;

  // Checks
  `DSS_ASSERT_IMP(a_mode_in_range, st_r == ST_MODE, n_r < cnt_r)
  `DSS_ASSERT_NXT(a_sample_starts, smp_xfer, st_r == ST_FEED)
  `DSS_ASSERT_NXT(a_load_no_busy, ld_xfer, (st_r == ST_IDLE) && !wb_en)
  `DSS_ASSERT_NXT(a_fin_delivers, (st_r == ST_FIN) && out_free, out_valid_r && (st_r == ST_IDLE))

endmodule

// ----- sv/dss_mac.sv -----
// Shared 16x32 multiplier with state and output accumulators.
`timescale 1ns / 1ps
module dss_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dss_pkg::mac_req_t                   req,
  output logic signed [dss_pkg::ACC_S_W-1:0]  acc_s,
  output logic signed [dss_pkg::ACC_Y_W-1:0]  acc_y
);
  import dss_pkg::*;

  logic signed [47:0]        prod_r;
  mac_op_t                   op_r;
  logic signed [ACC_S_W-1:0] acc_s_r;
  logic signed [ACC_S_W-1:0] acc_s_nxt;
  logic signed [ACC_Y_W-1:0] acc_y_r;
  logic signed [ACC_Y_W-1:0] acc_y_nxt;
  logic signed [ACC_S_W-1:0] p_s;
  logic signed [ACC_Y_W-1:0] p_y;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_NONE;
    end else begin
      op_r <= req.op;
    end
    prod_r <= req.a * req.b;
  end

  assign p_s = ACC_S_W'(prod_r);
  assign p_y = ACC_Y_W'(prod_r);

  // Accumulate stage.
  always_comb begin
    acc_s_nxt = acc_s_r;
    acc_y_nxt = acc_y_r;
    unique case (op_r)
      OP_S_LOAD:  acc_s_nxt = p_s;
      OP_S_ADD:   acc_s_nxt = acc_s_r + p_s;
      OP_S_SUB:   acc_s_nxt = acc_s_r - p_s;
      OP_S_ADDSH: acc_s_nxt = acc_s_r + (p_s <<< U_SHIFT);
      OP_Y_LDSH:  acc_y_nxt = p_y <<< U_SHIFT;
      OP_Y_ADD2:  acc_y_nxt = acc_y_r + (p_y <<< 1);
      OP_Y_SUB2:  acc_y_nxt = acc_y_r - (p_y <<< 1);
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_s_r <= acc_s_nxt;
    acc_y_r <= acc_y_nxt;
  end

  assign acc_s = acc_s_r;
  assign acc_y = acc_y_r;

endmodule
